[design/jump_stochastic_volatility_step_assert.svh]
// Assertion macros for the jump stochastic volatility step block.
// Used by the port checker; needs clk and rst_n in scope where expanded.
`ifndef JUMP_STOCHASTIC_VOLATILITY_STEP_ASSERT_SVH
`define JUMP_STOCHASTIC_VOLATILITY_STEP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JSV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/jsv_pkg.sv]
// Shared types, constants and saturation helpers for the jump stochastic
// volatility step block. No dependencies.
package jsv_pkg;

    localparam int WORD_W            = 32;
    localparam int PROD_W            = 2 * WORD_W;
    localparam int SUM_W             = WORD_W + 3;   // four 32-bit terms
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_INDEX_W       = 3;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRICE_REVERSION    = 3'd0,
        CFG_PRICE_MEAN         = 3'd1,
        CFG_VARIANCE_REVERSION = 3'd2,
        CFG_VARIANCE_MEAN      = 3'd3,
        CFG_VOL_OF_VOL         = 3'd4,
        CFG_CORRELATION        = 3'd5,
        CFG_DECORRELATION_GAIN = 3'd6
    } cfg_reg_t;

    // request to the square root unit
    typedef struct packed {
        logic                     start;
        logic signed [WORD_W-1:0] value;
    } sqrt_req_t;

    function automatic logic signed [SUM_W-1:0] sx_sum(input logic signed [WORD_W-1:0] x);
        return {{(SUM_W-WORD_W){x[WORD_W-1]}}, x};
    endfunction

    function automatic logic signed [SUM_W-1:0] zx_sum(input logic [WORD_W-2:0] x);
        return {{(SUM_W-WORD_W+1){1'b0}}, x};
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_sum(input logic signed [SUM_W-1:0] x);
        logic same;
        same = (&x[SUM_W-1:WORD_W-1]) | ~(|x[SUM_W-1:WORD_W-1]);
        if (same)
        begin
            return x[WORD_W-1:0];
        end
        return x[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_prod(input logic signed [PROD_W-1:0] x);
        logic same;
        same = (&x[PROD_W-1:WORD_W-1]) | ~(|x[PROD_W-1:WORD_W-1]);
        if (same)
        begin
            return x[WORD_W-1:0];
        end
        return x[PROD_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

endpackage

[design/jsv_ifs.sv]
// Valid/ready channel interfaces for step samples and step results.
// Depends on jsv_pkg for the word width.
interface jsv_sample_if;
    logic                              valid;
    logic                              ready;
    logic                              start_of_path;
    logic        [jsv_pkg::WORD_W-2:0] step_length;
    logic signed [jsv_pkg::WORD_W-1:0] increment_one;
    logic signed [jsv_pkg::WORD_W-1:0] increment_two;
    logic        [jsv_pkg::WORD_W-2:0] variance_jump;
    logic signed [jsv_pkg::WORD_W-1:0] price_jump;

    modport source (output valid, start_of_path, step_length, increment_one,
                    increment_two, variance_jump, price_jump, input ready);
    modport sink   (input valid, start_of_path, step_length, increment_one,
                    increment_two, variance_jump, price_jump, output ready);
endinterface

interface jsv_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [jsv_pkg::WORD_W-1:0] price;
    logic signed [jsv_pkg::WORD_W-1:0] variance;
    logic        [jsv_pkg::WORD_W-2:0] volatility;
    logic signed [jsv_pkg::WORD_W-1:0] price_return;

    modport source (output valid, price, variance, volatility, price_return,
                    input ready);
    modport sink   (input valid, price, variance, volatility, price_return,
                    output ready);
endinterface

[design/jsv_sqrt.sv]
// Bit-serial fixed-point square root: one root bit per cycle.
// Depends on jsv_pkg (sqrt_req_t, WORD_W).
module jsv_sqrt #(
    parameter  int FRACTION_BITS = jsv_pkg::FRACTION_BITS_DEF,
    localparam int ROOT_W        = (jsv_pkg::WORD_W + FRACTION_BITS) / 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  jsv_pkg::sqrt_req_t req,
    output logic               busy,
    output logic [ROOT_W-1:0]  root
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;

    logic [jsv_pkg::WORD_W-2:0] mag;
    logic [REM_W+1:0]           rem_sh;
    logic [REM_W+1:0]           trial;
    logic [REM_W+1:0]           diff;

    // negative and zero operands give a zero root
    assign mag    = req.value[jsv_pkg::WORD_W-1] ? '0 : req.value[jsv_pkg::WORD_W-2:0];
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign diff   = rem_sh - trial;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            rad_next  = {{(RAD_W-jsv_pkg::WORD_W+1){1'b0}}, mag} << FRACTION_BITS;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (!diff[REM_W+1])
            begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

[design/jump_stochastic_volatility_step.sv]
// Top level of the jump stochastic volatility step block.
// Depends on jsv_pkg, jsv_sample_if / jsv_result_if and jsv_sqrt.
//
// Advances one price series with stochastic variance and jumps by one Euler
// step per input word. All values are signed fixed point with FRACTION_BITS
// fraction bits; every product is floored and saturated to 32 bits, every
// update sum is taken at full width and saturated once. A word with
// start_of_path set reloads the series from the configured means plus the
// jumps and returns a zero price_return. Work is done by one 32x32 multiplier
// with a registered product, one accumulator adder and a bit-serial square
// root, stepped by a one-hot sequencer; the sample channel is ready only
// while the sequencer is idle. A normal step is dominated by its two square
// roots of ROOT_W = (32 + FRACTION_BITS)/2 bits each, one root bit per cycle;
// a start step waits only for the square root of its new variance. A finished
// word sits in the result register while the next sample is taken; the block
// stalls at the end of a step only if that register is still full.
// Configuration writes take effect at once and are meant for idle periods.
module jump_stochastic_volatility_step #(
    parameter int FRACTION_BITS = jsv_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [jsv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [jsv_pkg::WORD_W-1:0]          cfg_data,
    jsv_sample_if.sink                          sample,
    jsv_result_if.source                        result
);

    localparam int W      = jsv_pkg::WORD_W;
    localparam int ROOT_W = (W + FRACTION_BITS) / 2;

    typedef enum logic [21:0] {
        ST_IDLE   = 22'h000001,
        ST_SVSUM  = 22'h000002,  // start: mean + jump for variance
        ST_W2G    = 22'h000004,  // w2 * decorrelation gain
        ST_W1C    = 22'h000008,  // w1 * correlation
        ST_WSUM   = 22'h000010,  // correlated increment, issue variance drift
        ST_VRM    = 22'h000020,
        ST_VDT    = 22'h000040,
        ST_VACC   = 22'h000080,
        ST_VSQ    = 22'h000100,  // wait for sqrt of held variance
        ST_VOV    = 22'h000200,
        ST_VDIF   = 22'h000400,
        ST_VFIN   = 22'h000800,
        ST_VSAT   = 22'h001000,  // new variance, launch its sqrt
        ST_SPWAIT = 22'h002000,  // start: wait for volatility
        ST_PRM    = 22'h004000,
        ST_PDT    = 22'h008000,
        ST_PACC   = 22'h010000,
        ST_PSQ    = 22'h020000,  // wait for volatility, issue vol * w1
        ST_PVOL   = 22'h040000,
        ST_PSAT   = 22'h080000,
        ST_RET    = 22'h100000,
        ST_FIN    = 22'h200000   // hand word to result register
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic        [W-2:0] price_rev_reg;
    logic signed [W-1:0] price_mean_reg;
    logic        [W-2:0] var_rev_reg;
    logic        [W-2:0] var_mean_reg;
    logic        [W-2:0] vol_of_vol_reg;
    logic signed [17:0]  corr_reg;
    logic        [16:0]  decorr_reg;

    // series state
    logic signed [W-1:0] held_var_reg;
    logic signed [W-1:0] held_price_reg;

    // latched sample
    logic                start_reg;
    logic        [W-2:0] dt_reg;
    logic signed [W-1:0] w1_reg;
    logic signed [W-1:0] w2_reg;
    logic        [W-2:0] vjump_reg;
    logic signed [W-1:0] pjump_reg;

    // datapath
    logic signed [jsv_pkg::PROD_W-1:0] prod_reg;
    logic signed [jsv_pkg::PROD_W-1:0] prod_shr;
    logic signed [W-1:0]               mq;
    logic signed [W-1:0]               mul_a, mul_b;
    logic signed [jsv_pkg::SUM_W-1:0]  add_a, add_b, add_c;
    logic                              acc_load;
    logic signed [jsv_pkg::SUM_W-1:0]  acc_reg,  acc_next;
    logic signed [W-1:0]               t_reg,    t_next;
    logic signed [W-1:0]               w2c_reg,  w2c_next;
    logic signed [W-1:0]               vnew_reg, vnew_next;
    logic signed [W-1:0]               pnew_reg, pnew_next;
    logic signed [W-1:0]               vol_reg,  vol_next;
    logic signed [W-1:0]               ret_reg,  ret_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic                out_load;
    logic signed [W-1:0] out_price_reg;
    logic signed [W-1:0] out_var_reg;
    logic        [W-2:0] out_vol_reg;
    logic signed [W-1:0] out_ret_reg;

    logic                in_fire;
    jsv_pkg::sqrt_req_t  sq_req;
    logic                sq_busy;
    logic [ROOT_W-1:0]   sq_root;
    logic signed [W-1:0] root_word;

    jsv_sqrt #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .busy  (sq_busy),
        .root  (sq_root)
    );

    assign root_word = {{(W-ROOT_W){1'b0}}, sq_root};

    // floor of product / 2^F, saturated
    assign prod_shr = prod_reg >>> FRACTION_BITS;
    assign mq       = jsv_pkg::sat_prod(prod_shr);

    assign sample.ready = (state_reg == ST_IDLE);
    assign in_fire      = sample.valid && sample.ready;

    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        add_a      = '0;
        add_b      = '0;
        add_c      = '0;
        acc_load   = 1'b0;
        acc_next   = acc_reg;
        t_next     = t_reg;
        w2c_next   = w2c_reg;
        vnew_next  = vnew_reg;
        pnew_next  = pnew_reg;
        vol_next   = vol_reg;
        ret_next   = ret_reg;
        out_load   = 1'b0;
        sq_req     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // sqrt of held variance runs while the increments are mixed
                    sq_req.start = 1'b1;
                    sq_req.value = held_var_reg;
                    state_next   = sample.start_of_path ? ST_SVSUM : ST_W2G;
                end
            end
            ST_SVSUM:
            begin
                add_a      = jsv_pkg::zx_sum(var_mean_reg);
                add_b      = jsv_pkg::zx_sum(vjump_reg);
                acc_load   = 1'b1;
                state_next = ST_VSAT;
            end
            ST_W2G:
            begin
                mul_a      = w2_reg;
                mul_b      = {15'b0, decorr_reg};
                state_next = ST_W1C;
            end
            ST_W1C:
            begin
                t_next     = mq;
                mul_a      = w1_reg;
                mul_b      = {{14{corr_reg[17]}}, corr_reg};
                state_next = ST_WSUM;
            end
            ST_WSUM:
            begin
                w2c_next   = jsv_pkg::sat_sum(jsv_pkg::sx_sum(t_reg) + jsv_pkg::sx_sum(mq));
                mul_a      = {1'b0, var_rev_reg};
                mul_b      = jsv_pkg::sat_sum(jsv_pkg::zx_sum(var_mean_reg)
                                              - jsv_pkg::sx_sum(held_var_reg));
                state_next = ST_VRM;
            end
            ST_VRM:
            begin
                t_next     = mq;
                state_next = ST_VDT;
            end
            ST_VDT:
            begin
                mul_a      = t_reg;
                mul_b      = {1'b0, dt_reg};
                state_next = ST_VACC;
            end
            ST_VACC:
            begin
                add_a      = jsv_pkg::sx_sum(held_var_reg);
                add_b      = jsv_pkg::sx_sum(mq);
                add_c      = jsv_pkg::zx_sum(vjump_reg);
                acc_load   = 1'b1;
                state_next = ST_VSQ;
            end
            ST_VSQ:
            begin
                mul_a = {1'b0, vol_of_vol_reg};
                mul_b = root_word;
                if (!sq_busy)
                begin
                    state_next = ST_VOV;
                end
            end
            ST_VOV:
            begin
                t_next     = mq;
                state_next = ST_VDIF;
            end
            ST_VDIF:
            begin
                mul_a      = t_reg;
                mul_b      = w2c_reg;
                state_next = ST_VFIN;
            end
            ST_VFIN:
            begin
                add_a      = acc_reg;
                add_b      = jsv_pkg::sx_sum(mq);
                acc_load   = 1'b1;
                state_next = ST_VSAT;
            end
            ST_VSAT:
            begin
                vnew_next    = jsv_pkg::sat_sum(acc_reg);
                sq_req.start = 1'b1;
                sq_req.value = jsv_pkg::sat_sum(acc_reg);
                if (start_reg)
                begin
                    add_a      = jsv_pkg::sx_sum(price_mean_reg);
                    add_b      = jsv_pkg::sx_sum(pjump_reg);
                    acc_load   = 1'b1;
                    state_next = ST_SPWAIT;
                end
                else
                begin
                    mul_a      = {1'b0, price_rev_reg};
                    mul_b      = jsv_pkg::sat_sum(jsv_pkg::sx_sum(price_mean_reg)
                                                  - jsv_pkg::sx_sum(held_price_reg));
                    state_next = ST_PRM;
                end
            end
            ST_SPWAIT:
            begin
                if (!sq_busy)
                begin
                    vol_next   = root_word;
                    pnew_next  = jsv_pkg::sat_sum(acc_reg);
                    ret_next   = '0;
                    state_next = ST_FIN;
                end
            end
            ST_PRM:
            begin
                t_next     = mq;
                state_next = ST_PDT;
            end
            ST_PDT:
            begin
                mul_a      = t_reg;
                mul_b      = {1'b0, dt_reg};
                state_next = ST_PACC;
            end
            ST_PACC:
            begin
                add_a      = jsv_pkg::sx_sum(held_price_reg);
                add_b      = jsv_pkg::sx_sum(mq);
                add_c      = jsv_pkg::sx_sum(pjump_reg);
                acc_load   = 1'b1;
                state_next = ST_PSQ;
            end
            ST_PSQ:
            begin
                mul_a = root_word;
                mul_b = w1_reg;
                if (!sq_busy)
                begin
                    vol_next   = root_word;
                    state_next = ST_PVOL;
                end
            end
            ST_PVOL:
            begin
                add_a      = acc_reg;
                add_b      = jsv_pkg::sx_sum(mq);
                acc_load   = 1'b1;
                state_next = ST_PSAT;
            end
            ST_PSAT:
            begin
                pnew_next  = jsv_pkg::sat_sum(acc_reg);
                state_next = ST_RET;
            end
            ST_RET:
            begin
                ret_next   = jsv_pkg::sat_sum(jsv_pkg::sx_sum(pnew_reg)
                                              - jsv_pkg::sx_sum(held_price_reg));
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait here only if the previous word was not taken yet
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (acc_load)
        begin
            acc_next = add_a + add_b + add_c;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control, configuration and series state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            held_var_reg   <= '0;
            held_price_reg <= '0;
            price_rev_reg  <= '0;
            price_mean_reg <= '0;
            var_rev_reg    <= '0;
            var_mean_reg   <= '0;
            vol_of_vol_reg <= '0;
            corr_reg       <= '0;
            decorr_reg     <= 17'(64'd1 << FRACTION_BITS);  // 1.0
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                held_var_reg   <= vnew_reg;
                held_price_reg <= pnew_reg;
            end
            if (cfg_write)
            begin
                unique case (jsv_pkg::cfg_reg_t'(cfg_index))
                    jsv_pkg::CFG_PRICE_REVERSION:    price_rev_reg  <= cfg_data[W-2:0];
                    jsv_pkg::CFG_PRICE_MEAN:         price_mean_reg <= cfg_data;
                    jsv_pkg::CFG_VARIANCE_REVERSION: var_rev_reg    <= cfg_data[W-2:0];
                    jsv_pkg::CFG_VARIANCE_MEAN:      var_mean_reg   <= cfg_data[W-2:0];
                    jsv_pkg::CFG_VOL_OF_VOL:         vol_of_vol_reg <= cfg_data[W-2:0];
                    jsv_pkg::CFG_CORRELATION:        corr_reg       <= cfg_data[17:0];
                    jsv_pkg::CFG_DECORRELATION_GAIN: decorr_reg     <= cfg_data[16:0];
                    default:
                    begin
                        // unmapped index: ignored
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            start_reg <= sample.start_of_path;
            dt_reg    <= sample.step_length;
            w1_reg    <= sample.increment_one;
            w2_reg    <= sample.increment_two;
            vjump_reg <= sample.variance_jump;
            pjump_reg <= sample.price_jump;
        end
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        t_reg    <= t_next;
        w2c_reg  <= w2c_next;
        vnew_reg <= vnew_next;
        pnew_reg <= pnew_next;
        vol_reg  <= vol_next;
        ret_reg  <= ret_next;
        if (out_load)
        begin
            out_price_reg <= pnew_reg;
            out_var_reg   <= vnew_reg;
            out_vol_reg   <= vol_reg[W-2:0];
            out_ret_reg   <= ret_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.price        = out_price_reg;
    assign result.variance     = out_var_reg;
    assign result.volatility   = out_vol_reg;
    assign result.price_return = out_ret_reg;

endmodule

[design/jsv_checker.sv]
// Port-level checker for jump_stochastic_volatility_step, bound to the top.
// Depends on jump_stochastic_volatility_step_assert.svh and jsv_pkg.
`include "jump_stochastic_volatility_step_assert.svh"

module jsv_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [jsv_pkg::WORD_W-1:0] out_price,
    input logic signed [jsv_pkg::WORD_W-1:0] out_variance,
    input logic        [jsv_pkg::WORD_W-2:0] out_volatility,
    input logic signed [jsv_pkg::WORD_W-1:0] out_price_return
);

    // one step in flight: a taken sample drops ready for the next cycle
    `JSV_ASSERT_NEXT(a_one_step, in_valid && in_ready, !in_ready, "sample taken while busy")

    // a negative variance has zero volatility
    `JSV_ASSERT_SAME(a_neg_var_vol, out_valid && out_variance[jsv_pkg::WORD_W-1], out_volatility == '0, "volatility of negative variance")

    `JSV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")

    `JSV_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_price) && $stable(out_variance) && $stable(out_volatility) && $stable(out_price_return), "stalled result changed")

endmodule

bind jump_stochastic_volatility_step jsv_checker u_jsv_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (sample.valid),
    .in_ready         (sample.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_price        (result.price),
    .out_variance     (result.variance),
    .out_volatility   (result.volatility),
    .out_price_return (result.price_return)
);
